FILE: src/pat_pkg.sv
`default_nettype none
package pat_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int SCAN_W = IDX_W + 1;

  localparam logic [31:0] DAY_SECONDS = 32'd86400;
  localparam logic [7:0] COUNT_MAX = 8'hff;

  localparam logic [7:0] HORIZON_RST = 8'd30;
  localparam logic [7:0] RETRY_RST = 8'd3;
  localparam logic [7:0] MAXF_RST = 8'd10;
  localparam logic [7:0] MINFAIL_RST = 8'd7;
  localparam logic [7:0] DEMOTE_RST = 8'd10;
  localparam logic [15:0] GRACE_RST = 16'd60;
  localparam logic [15:0] FUTURE_RST = 16'd600;
  localparam logic [31:0] MAXAGE_RST = 32'd315360000;

  localparam int KEY_W = 144;
  localparam int DATA_W = 136;

  typedef enum logic [2:0] {
    REG_HORIZON = 3'd0,
    REG_RETRY   = 3'd1,
    REG_MAXF    = 3'd2,
    REG_MINFAIL = 3'd3,
    REG_DEMOTE  = 3'd4,
    REG_GRACE   = 3'd5,
    REG_FUTURE  = 3'd6,
    REG_MAXAGE  = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    REQ_ADD     = 2'd0,
    REQ_ATTEMPT = 2'd1,
    REQ_GOOD    = 2'd2,
    REQ_FAILED  = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    ST_ADDED      = 4'd0,
    ST_UNROUTABLE = 4'd1,
    ST_PRESENT    = 4'd2,
    ST_TERRIBLE   = 4'd3,
    ST_FULL       = 4'd4,
    ST_UPDATED    = 4'd5,
    ST_PROMOTED   = 4'd6,
    ST_DEMOTED    = 4'd7,
    ST_REMOVED    = 4'd8,
    ST_NOT_FOUND  = 4'd9
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH,
    S_UPDATE
  } state_e;

  typedef struct packed {
    logic capture;
    logic scan;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic [15:0] grace;
    logic [15:0] future;
    logic [7:0]  retry;
    logic [7:0]  maxf;
    logic [31:0] hor_thr;
    logic [31:0] minf_thr;
  } cfg_t;

  typedef struct packed {
    logic [31:0] seen;
    logic [31:0] tried_at;
    logic [31:0] counted;
    logic [31:0] success;
    logic [7:0]  count;
  } entry_t;

  function automatic logic terrible(logic [31:0] seen, logic [31:0] tr, logic [31:0] succ,
                                    logic [7:0] cnt, logic [31:0] now, cfg_t c);
    logic r;
    r = 1'b0;
    if (tr != 32'd0 && now > tr && (now - tr) < {16'd0, c.grace}) begin
      r = 1'b0;
    end else if (seen > now && (seen - now) > {16'd0, c.future}) begin
      r = 1'b1;
    end else if (seen != 32'd0 && now > seen && (now - seen) >= c.hor_thr) begin
      r = 1'b1;
    end else if (succ == 32'd0 && cnt >= c.retry) begin
      r = 1'b1;
    end else if (succ != 32'd0 && now > succ && cnt >= c.maxf &&
                 (now - succ) >= c.minf_thr) begin
      r = 1'b1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: src/peer_address_table_top.sv
// a result follows the input transfer after the key search, which reads one entry of the
// key memory per cycle, then the entry data fetch and the table update
// one request at a time: the next input is taken only after the previous table update
// a waiting result does not block the next input transfer
// reset: asynchronous active low; table empty, counts zero, registers at defaults
`default_nettype none
module peer_address_table_top import pat_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // addr_upper, addr_lower, port_number, seen_time, count_failure, now_time, pad
  input  wire logic [215:0] s_axis_tdata,
  // req_type
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // status, in_tried, attempt_count, new_total, tried_total, pad
  output logic [31:0]       m_axis_tdata,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_addr_i,
  input  wire logic [31:0]  cfg_wdata_i
);

  cmd_t       cmd;
  sts_t       sts;
  logic [3:0] status;
  logic       in_tried;
  logic [7:0] attempt_count;
  logic [8:0] new_total, tried_total;

  pat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pat_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .req_type_i      (s_axis_tuser),
    .addr_upper_i    (s_axis_tdata[63:0]),
    .addr_lower_i    (s_axis_tdata[127:64]),
    .port_number_i   (s_axis_tdata[143:128]),
    .seen_time_i     (s_axis_tdata[175:144]),
    .count_failure_i (s_axis_tdata[176]),
    .now_time_i      (s_axis_tdata[208:177]),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .status_o        (status),
    .in_tried_o      (in_tried),
    .attempt_count_o (attempt_count),
    .new_total_o     (new_total),
    .tried_total_o   (tried_total)
  );

  assign m_axis_tdata = {1'b0, tried_total, new_total, attempt_count, in_tried, status};

endmodule
`default_nettype wire

FILE: src/pat_ram.sv
`default_nettype none
module pat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

FILE: src/pat_ctrl.sv
`default_nettype none
module pat_ctrl import pat_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        state_d = S_UPDATE;
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: src/pat_dpath.sv
`default_nettype none
module pat_dpath import pat_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire cmd_t         cmd_i,
  output sts_t              sts_o,
  input  wire logic [1:0]   req_type_i,
  input  wire logic [63:0]  addr_upper_i,
  input  wire logic [63:0]  addr_lower_i,
  input  wire logic [15:0]  port_number_i,
  input  wire logic [31:0]  seen_time_i,
  input  wire logic         count_failure_i,
  input  wire logic [31:0]  now_time_i,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_addr_i,
  input  wire logic [31:0]  cfg_wdata_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [3:0]        status_o,
  output logic              in_tried_o,
  output logic [7:0]        attempt_count_o,
  output logic [8:0]        new_total_o,
  output logic [8:0]        tried_total_o
);

  localparam logic [SCAN_W-1:0] SCAN_END = SCAN_W'(TABLE_ENTRIES);
  localparam logic [CNT_W:0] FULL_CNT = (CNT_W + 1)'(TABLE_ENTRIES);

  // configuration
  logic [7:0]  horizon_q, retry_q, maxf_q, minfail_q, demote_q;
  logic [15:0] grace_q, future_q;
  logic [31:0] maxage_q, hor_thr_q, minf_thr_q;
  cfg_t        cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      horizon_q <= HORIZON_RST;
      retry_q   <= RETRY_RST;
      maxf_q    <= MAXF_RST;
      minfail_q <= MINFAIL_RST;
      demote_q  <= DEMOTE_RST;
      grace_q   <= GRACE_RST;
      future_q  <= FUTURE_RST;
      maxage_q  <= MAXAGE_RST;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_addr_i))
        REG_HORIZON: horizon_q <= cfg_wdata_i[7:0];
        REG_RETRY:   retry_q   <= cfg_wdata_i[7:0];
        REG_MAXF:    maxf_q    <= cfg_wdata_i[7:0];
        REG_MINFAIL: minfail_q <= cfg_wdata_i[7:0];
        REG_DEMOTE:  demote_q  <= cfg_wdata_i[7:0];
        REG_GRACE:   grace_q   <= cfg_wdata_i[15:0];
        REG_FUTURE:  future_q  <= cfg_wdata_i[15:0];
        REG_MAXAGE:  maxage_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // day thresholds so that no divide is needed
  always_ff @(posedge clk_i) begin
    hor_thr_q  <= 32'(({24'd0, horizon_q} + 32'd1) * DAY_SECONDS);
    minf_thr_q <= 32'({24'd0, minfail_q} * DAY_SECONDS);
  end

  assign cfg.grace    = grace_q;
  assign cfg.future   = future_q;
  assign cfg.retry    = retry_q;
  assign cfg.maxf     = maxf_q;
  assign cfg.hor_thr  = hor_thr_q;
  assign cfg.minf_thr = minf_thr_q;

  // request
  req_e        kind_q;
  logic [63:0] up_q, lo_q;
  logic [15:0] port_q;
  logic [31:0] seen_q, now_q;
  logic        cf_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= req_e'(req_type_i);
      up_q   <= addr_upper_i;
      lo_q   <= (addr_upper_i == 64'd0 && addr_lower_i[63:32] == 32'd0 &&
                 addr_lower_i[31:0] != 32'd0) ?
                (addr_lower_i | 64'h0000_ffff_0000_0000) : addr_lower_i;
      port_q <= port_number_i;
      seen_q <= seen_time_i;
      cf_q   <= count_failure_i;
      now_q  <= now_time_i;
    end
  end

  // memories
  logic             key_we, data_we;
  logic [IDX_W-1:0] data_waddr;
  logic [KEY_W-1:0] key_rdata;
  entry_t           data_wdata, data_rdata;
  logic [DATA_W-1:0] data_rraw;

  logic [SCAN_W-1:0] scan_q, scan_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]  cmp_idx_q, cmp_idx_d;
  logic              found_q, found_d, free_found_q, free_found_d;
  logic [IDX_W-1:0]  hit_q, hit_d, free_q, free_d;

  pat_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (free_q),
    .wdata_i ({port_q, lo_q, up_q}),
    .raddr_i (scan_q[IDX_W-1:0]),
    .rdata_o (key_rdata)
  );

  pat_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_ENTRIES)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (data_waddr),
    .wdata_i (data_wdata),
    .raddr_i (hit_q),
    .rdata_o (data_rraw)
  );

  assign data_rdata = entry_t'(data_rraw);

  logic [TABLE_ENTRIES-1:0] valid_q, tried_q;

  // sequential key search
  always_comb begin
    scan_d       = scan_q;
    cmp_vld_d    = 1'b0;
    cmp_idx_d    = cmp_idx_q;
    found_d      = found_q;
    hit_d        = hit_q;
    free_found_d = free_found_q;
    free_d       = free_q;
    if (cmd_i.capture) begin
      scan_d       = '0;
      found_d      = 1'b0;
      free_found_d = 1'b0;
    end else if (cmd_i.scan) begin
      if (cmp_vld_q && !found_q && key_rdata == {port_q, lo_q, up_q}) begin
        found_d = 1'b1;
        hit_d   = cmp_idx_q;
      end
      if (scan_q < SCAN_END) begin
        cmp_vld_d = valid_q[scan_q[IDX_W-1:0]];
        cmp_idx_d = scan_q[IDX_W-1:0];
        if (!valid_q[scan_q[IDX_W-1:0]] && !free_found_q) begin
          free_found_d = 1'b1;
          free_d       = scan_q[IDX_W-1:0];
        end
        scan_d = scan_q + SCAN_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q       <= '0;
      cmp_vld_q    <= 1'b0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      scan_q       <= scan_d;
      cmp_vld_q    <= cmp_vld_d;
      found_q      <= found_d;
      free_found_q <= free_found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    hit_q     <= hit_d;
    free_q    <= free_d;
  end

  // update
  logic [CNT_W-1:0] new_q, new_d, tcnt_q, tcnt_d;
  logic [31:0]      lastgood_q, lastgood_d;
  logic [TABLE_ENTRIES-1:0] valid_d, tried_d;
  logic             fire, out_valid_q;
  logic [3:0]       status_q, status_d;
  logic             otried_q, otried_d;
  logic [7:0]       ocnt_q, ocnt_d;

  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.scan_done = (scan_q == SCAN_END);
  assign fire = cmd_i.update && sts_o.out_free;

  always_comb begin
    logic [31:0] eff0, eff;
    logic [7:0]  c;
    entry_t      e;
    eff0       = (seen_q == 32'd0) ? now_q : seen_q;
    eff        = (eff0 > now_q || (now_q - eff0) > maxage_q) ? now_q : eff0;
    c          = (data_rdata.count == COUNT_MAX) ? COUNT_MAX : data_rdata.count + 8'd1;
    e          = data_rdata;
    new_d      = new_q;
    tcnt_d     = tcnt_q;
    lastgood_d = lastgood_q;
    valid_d    = valid_q;
    tried_d    = tried_q;
    key_we     = 1'b0;
    data_we    = 1'b0;
    data_waddr = hit_q;
    status_d   = ST_NOT_FOUND;
    otried_d   = 1'b0;
    ocnt_d     = 8'd0;
    case (kind_q)
      REQ_ADD: begin
        if (port_q == 16'd0 || (up_q == 64'd0 && lo_q == 64'd0)) begin
          status_d = ST_UNROUTABLE;
        end else if (found_q) begin
          if (eff > e.seen) begin
            e.seen = eff;
          end
          data_we  = 1'b1;
          status_d = ST_PRESENT;
          otried_d = tried_q[hit_q];
          ocnt_d   = e.count;
        end else if (terrible(eff, 32'd0, 32'd0, 8'd0, now_q, cfg)) begin
          status_d = ST_TERRIBLE;
        end else if ({1'b0, new_q} + {1'b0, tcnt_q} >= FULL_CNT || !free_found_q) begin
          status_d = ST_FULL;
        end else begin
          e          = '0;
          e.seen     = eff;
          key_we     = 1'b1;
          data_we    = 1'b1;
          data_waddr = free_q;
          valid_d[free_q] = 1'b1;
          tried_d[free_q] = 1'b0;
          new_d    = new_q + CNT_W'(1);
          status_d = ST_ADDED;
        end
      end
      REQ_ATTEMPT: begin
        if (found_q) begin
          e.tried_at = now_q;
          if (cf_q && e.counted < lastgood_q) begin
            e.counted = now_q;
            e.count   = c;
          end
          data_we  = 1'b1;
          status_d = ST_UPDATED;
          otried_d = tried_q[hit_q];
          ocnt_d   = e.count;
        end
      end
      REQ_GOOD: begin
        lastgood_d = now_q;
        if (found_q) begin
          e.success = now_q;
          e.count   = 8'd0;
          data_we   = 1'b1;
          otried_d  = 1'b1;
          if (!tried_q[hit_q]) begin
            tried_d[hit_q] = 1'b1;
            if (new_q != '0) begin
              new_d = new_q - CNT_W'(1);
            end
            tcnt_d   = tcnt_q + CNT_W'(1);
            status_d = ST_PROMOTED;
          end else begin
            status_d = ST_UPDATED;
          end
        end
      end
      REQ_FAILED: begin
        if (found_q) begin
          e.count  = c;
          data_we  = 1'b1;
          ocnt_d   = c;
          otried_d = tried_q[hit_q];
          status_d = ST_UPDATED;
          if (!tried_q[hit_q]) begin
            if (terrible(e.seen, e.tried_at, e.success, c, now_q, cfg)) begin
              valid_d[hit_q] = 1'b0;
              if (new_q != '0) begin
                new_d = new_q - CNT_W'(1);
              end
              status_d = ST_REMOVED;
              ocnt_d   = 8'd0;
            end
          end else if (c >= demote_q) begin
            tried_d[hit_q] = 1'b0;
            if (tcnt_q != '0) begin
              tcnt_d = tcnt_q - CNT_W'(1);
            end
            new_d    = new_q + CNT_W'(1);
            status_d = ST_DEMOTED;
            otried_d = 1'b0;
          end
        end
      end
      default: ;
    endcase
    key_we     = key_we && fire;
    data_we    = data_we && fire;
    data_wdata = e;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      tried_q     <= '0;
      new_q       <= '0;
      tcnt_q      <= '0;
      lastgood_q  <= 32'd1;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        valid_q    <= valid_d;
        tried_q    <= tried_d;
        new_q      <= new_d;
        tcnt_q     <= tcnt_d;
        lastgood_q <= lastgood_d;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= status_d;
      otried_q <= otried_d;
      ocnt_q   <= ocnt_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign in_tried_o      = otried_q;
  assign attempt_count_o = ocnt_q;
  assign new_total_o     = 9'(new_q);
  assign tried_total_o   = 9'(tcnt_q);

endmodule
`default_nettype wire

FILE: src/pat_checker.sv
`default_nettype none
module pat_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [31:0]  m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_no_fast_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result too soon after transfer");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[3:0] <= 4'd9)
    else $error("bad status code");

  a_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ({1'b0, m_axis_tdata[21:13]} + {1'b0, m_axis_tdata[30:22]}) <= 10'd256)
    else $error("class totals exceed table size");

endmodule

bind peer_address_table_top pat_checker u_pat_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import pat_pkg::*;

  localparam int POOL_SIZE = 24;
  localparam int SETTLE_CYCLES = 300;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct {
    logic [63:0] up;
    logic [63:0] lo;
    logic [15:0] port;
  } peer_key_t;

  class pat_scoreboard;
    logic [7:0]  horizon, retry, maxf, minfail, demote;
    logic [15:0] grace, future;
    logic [31:0] maxage;
    bit          valid[TABLE_ENTRIES];
    bit          tried[TABLE_ENTRIES];
    logic [63:0] ku[TABLE_ENTRIES];
    logic [63:0] kl[TABLE_ENTRIES];
    logic [15:0] kp[TABLE_ENTRIES];
    logic [31:0] seen_s[TABLE_ENTRIES];
    logic [31:0] try_s[TABLE_ENTRIES];
    logic [31:0] cnt_s[TABLE_ENTRIES];
    logic [31:0] succ_s[TABLE_ENTRIES];
    logic [7:0]  fails[TABLE_ENTRIES];
    logic [31:0] good_time;
    int unsigned n_new, n_tried;
    logic [31:0] expected_q[$];
    int errors, checked;
    int status_hits[10];

    function new();
      horizon = HORIZON_RST; retry = RETRY_RST; maxf = MAXF_RST; minfail = MINFAIL_RST;
      demote = DEMOTE_RST; grace = GRACE_RST; future = FUTURE_RST; maxage = MAXAGE_RST;
      foreach (valid[i]) begin
        valid[i] = 0;
        tried[i] = 0;
      end
      good_time = 32'd1;
      n_new = 0;
      n_tried = 0;
      errors = 0;
      checked = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function void set_reg(reg_idx_e r, logic [31:0] v);
      case (r)
        REG_HORIZON: horizon = v[7:0];
        REG_RETRY:   retry = v[7:0];
        REG_MAXF:    maxf = v[7:0];
        REG_MINFAIL: minfail = v[7:0];
        REG_DEMOTE:  demote = v[7:0];
        REG_GRACE:   grace = v[15:0];
        REG_FUTURE:  future = v[15:0];
        default:     maxage = v;
      endcase
    endfunction

    function bit peer_unfit(logic [31:0] seen, logic [31:0] tr, logic [31:0] succ,
                            logic [7:0] cnt, logic [31:0] now);
      if (tr != 0 && now > tr && (now - tr) < {16'd0, grace}) return 0;
      if (seen > now && (seen - now) > {16'd0, future}) return 1;
      if (seen != 0 && now > seen && (now - seen) / DAY_SECONDS > {24'd0, horizon}) return 1;
      if (succ == 0 && cnt >= retry) return 1;
      if (succ != 0 && now > succ && cnt >= maxf &&
          (now - succ) / DAY_SECONDS >= {24'd0, minfail}) return 1;
      return 0;
    endfunction

    function logic [7:0] bump(logic [7:0] c);
      return (c == COUNT_MAX) ? COUNT_MAX : c + 8'd1;
    endfunction

    function void note_request(req_e kind, logic [63:0] up, logic [63:0] lo_in,
                               logic [15:0] port, logic [31:0] seen, bit cf,
                               logic [31:0] now);
      logic [63:0] lo;
      logic [31:0] eff;
      status_e st;
      bit      t_out;
      logic [7:0] c_out;
      int idx, slot;
      lo = lo_in;
      st = ST_NOT_FOUND;
      t_out = 0;
      c_out = 0;
      idx = -1;
      slot = -1;
      if (up == 0 && lo[63:32] == 0 && lo[31:0] != 0) lo[47:32] = 16'hffff;
      for (int i = 0; i < TABLE_ENTRIES; i++)
        if (idx < 0 && valid[i] && ku[i] == up && kl[i] == lo && kp[i] == port) idx = i;
      case (kind)
        REQ_ADD: begin
          eff = (seen == 0) ? now : seen;
          if (eff > now || now - eff > maxage) eff = now;
          if (port == 0 || (up == 0 && lo == 0)) begin
            st = ST_UNROUTABLE;
          end else if (idx >= 0) begin
            if (eff > seen_s[idx]) seen_s[idx] = eff;
            st = ST_PRESENT;
            t_out = tried[idx];
            c_out = fails[idx];
          end else if (peer_unfit(eff, 0, 0, 0, now)) begin
            st = ST_TERRIBLE;
          end else if (n_new + n_tried >= TABLE_ENTRIES) begin
            st = ST_FULL;
          end else begin
            for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
              if (!valid[i]) slot = i;
            if (slot < 0) begin
              st = ST_FULL;
            end else begin
              valid[slot] = 1;
              tried[slot] = 0;
              ku[slot] = up;
              kl[slot] = lo;
              kp[slot] = port;
              seen_s[slot] = eff;
              try_s[slot] = 0;
              cnt_s[slot] = 0;
              succ_s[slot] = 0;
              fails[slot] = 0;
              n_new++;
              st = ST_ADDED;
            end
          end
        end
        REQ_ATTEMPT: begin
          if (idx >= 0) begin
            try_s[idx] = now;
            if (cf && cnt_s[idx] < good_time) begin
              cnt_s[idx] = now;
              fails[idx] = bump(fails[idx]);
            end
            st = ST_UPDATED;
          end
        end
        REQ_GOOD: begin
          good_time = now;
          if (idx >= 0) begin
            succ_s[idx] = now;
            fails[idx] = 0;
            if (!tried[idx]) begin
              tried[idx] = 1;
              if (n_new > 0) n_new--;
              n_tried++;
              st = ST_PROMOTED;
            end else begin
              st = ST_UPDATED;
            end
          end
        end
        default: begin
          if (idx >= 0) begin
            fails[idx] = bump(fails[idx]);
            if (!tried[idx]) begin
              if (peer_unfit(seen_s[idx], try_s[idx], succ_s[idx], fails[idx], now)) begin
                valid[idx] = 0;
                if (n_new > 0) n_new--;
                st = ST_REMOVED;
                idx = -1;
              end else begin
                st = ST_UPDATED;
              end
            end else if (fails[idx] >= demote) begin
              tried[idx] = 0;
              if (n_tried > 0) n_tried--;
              n_new++;
              st = ST_DEMOTED;
            end else begin
              st = ST_UPDATED;
            end
          end
        end
      endcase
      if (kind != REQ_ADD && idx >= 0) begin
        t_out = tried[idx];
        c_out = fails[idx];
      end
      expected_q.insert(expected_q.size(),
                        {1'b0, n_tried[8:0], n_new[8:0], c_out, t_out, st});
    endfunction

    task report(string msg);
      $display("mismatch @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [31:0] got);
      logic [31:0] exp_w;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      exp_w = expected_q.pop_front();
      checked++;
      if (exp_w[3:0] < 10) status_hits[exp_w[3:0]]++;
      if (got[3:0] !== exp_w[3:0])
        report($sformatf("status %0d, expected %0d", got[3:0], exp_w[3:0]));
      if (got[4] !== exp_w[4])
        report($sformatf("in_tried %0b, expected %0b", got[4], exp_w[4]));
      if (got[12:5] !== exp_w[12:5])
        report($sformatf("attempt_count %0d, expected %0d", got[12:5], exp_w[12:5]));
      if (got[21:13] !== exp_w[21:13])
        report($sformatf("new_total %0d, expected %0d", got[21:13], exp_w[21:13]));
      if (got[30:22] !== exp_w[30:22])
        report($sformatf("tried_total %0d, expected %0d", got[30:22], exp_w[30:22]));
    endtask
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [215:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [31:0]  m_axis_tdata;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_addr_i = '0;
  logic [31:0]  cfg_wdata_i = '0;

  pat_scoreboard sb = new();
  peer_key_t     pool[POOL_SIZE];
  logic [31:0]   clock_now;
  bit            quiet = 0;
  int            cycles = 0;
  int            stall_left = 0;
  int            sent = 0;

  peer_address_table_top uut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task send_req(req_e kind, peer_key_t k, logic [31:0] seen, bit cf, logic [31:0] now);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {7'd0, now, cf, seen, k.port, k.lo, k.up};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(kind, k.up, k.lo, k.port, seen, cf, now);
    sent++;
  endtask

  task settle();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task write_regs(logic [31:0] vals[8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we_i <= 1'b1;
      cfg_addr_i <= i[2:0];
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
      sb.set_reg(reg_idx_e'(i), vals[i]);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function peer_key_t fresh_key();
    peer_key_t k;
    k.up = {$urandom, $urandom};
    k.lo = {$urandom, $urandom};
    k.port = $urandom_range(1, 65535);
    if ($urandom_range(0, 9) == 0) k.up = 0;
    if ($urandom_range(0, 19) == 0) k.port = 0;
    return k;
  endfunction

  task advance_clock();
    case ($urandom_range(0, 19))
      0:       clock_now = $urandom;
      1, 2, 3: clock_now = clock_now + $urandom_range(0, 2 * 86400);
      default: clock_now = clock_now + $urandom_range(0, 120);
    endcase
  endtask

  task random_req(bit fill_only);
    peer_key_t k;
    logic [31:0] seen;
    req_e kind;
    advance_clock();
    if (fill_only) begin
      k = fresh_key();
      k.port = $urandom_range(1, 65535);
      send_req(REQ_ADD, k, 32'd0, $urandom_range(0, 1), clock_now);
      return;
    end
    kind = req_e'($urandom_range(0, 3));
    k = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, POOL_SIZE - 1)] : fresh_key();
    case ($urandom_range(0, 5))
      0: seen = 0;
      1: seen = clock_now - $urandom_range(0, 90 * 86400);
      2: seen = clock_now + $urandom_range(0, 2000);
      3: seen = $urandom;
      4: seen = clock_now;
      default: seen = clock_now - $urandom_range(0, 3000);
    endcase
    send_req(kind, k, seen, $urandom_range(0, 1), clock_now);
  endtask

  logic [31:0] regs[8];
  peer_key_t   dk, v4, tk;

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool[i] = fresh_key();
      pool[i].port = $urandom_range(1, 65535);
      if (i % 4 == 1) begin
        pool[i].up = 0;
        pool[i].lo = {32'd0, $urandom | 32'd1};
      end else if (i % 4 == 2) begin
        pool[i] = pool[i - 1];
        pool[i].lo[47:32] = 16'hffff;
      end
    end
    pool[POOL_SIZE - 2].port = 0;
    pool[POOL_SIZE - 1].up = 0;
    pool[POOL_SIZE - 1].lo = 0;
    clock_now = 32'd400000000;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: normalization, clamps, promote, demote, removal
    v4 = pool[1];
    send_req(REQ_ADD, v4, 0, 0, clock_now);
    send_req(REQ_ADD, pool[2], clock_now - 5, 0, clock_now);
    send_req(REQ_ADD, pool[POOL_SIZE - 2], 0, 0, clock_now);
    send_req(REQ_ADD, pool[POOL_SIZE - 1], 0, 0, clock_now);
    dk.up = '1; dk.lo = '1; dk.port = 16'hffff;
    send_req(REQ_ADD, dk, 32'hffffffff, 1, clock_now);
    send_req(REQ_ADD, pool[0], 32'd5, 0, clock_now);
    send_req(REQ_ADD, pool[3], clock_now - 40 * 86400, 0, clock_now + 1);
    tk = fresh_key();
    tk.port = 16'd1;
    send_req(REQ_ATTEMPT, tk, 0, 1, clock_now);
    send_req(REQ_ATTEMPT, v4, 0, 1, clock_now + 2);
    send_req(REQ_ATTEMPT, v4, 0, 1, clock_now + 3);
    send_req(REQ_ATTEMPT, v4, 0, 0, clock_now + 4);
    send_req(REQ_GOOD, tk, 0, 0, clock_now + 5);
    send_req(REQ_GOOD, v4, 0, 0, clock_now + 6);
    send_req(REQ_GOOD, pool[2], 0, 0, clock_now + 7);
    for (int i = 0; i < 10; i++)
      send_req(REQ_FAILED, v4, 0, 0, clock_now + 10 + i);
    for (int i = 0; i < 3; i++)
      send_req(REQ_FAILED, dk, 0, 0, clock_now + 100000 + i);
    send_req(REQ_FAILED, pool[0], 0, 0, 32'hffffffff);
    send_req(REQ_ADD, pool[5], 0, 1, 32'd0);

    for (int i = 0; i < 400; i++) random_req(0);
    for (int i = 0; i < 290; i++) random_req(1);
    for (int i = 0; i < 100; i++) random_req(0);
    settle();

    regs = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 16'd0, 16'd0, 32'd0};
    write_regs(regs);
    for (int i = 0; i < 300; i++) random_req(0);
    settle();

    regs = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 16'hffff, 16'hffff, 32'hffffffff};
    write_regs(regs);
    for (int i = 0; i < 300; i++) random_req(0);
    settle();

    regs = '{$urandom_range(0, 255), $urandom_range(1, 6), $urandom_range(0, 12),
             $urandom_range(0, 10), $urandom_range(1, 12), $urandom_range(0, 300),
             $urandom_range(0, 3000), $urandom};
    write_regs(regs);
    for (int i = 0; i < 500; i++) begin
      if (i == 300) quiet = 1;
      random_req(0);
    end
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("%0d requests sent, %0d results checked over four register settings",
             sent, sb.checked);
    $display("status counts added..not found: %p", sb.status_hits);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: peer_address_table_top.f
src/pat_pkg.sv
src/pat_ram.sv
src/pat_ctrl.sv
src/pat_dpath.sv
src/peer_address_table_top.sv
src/pat_checker.sv
tb/tb.sv
